// ===== rtl/core/spq_pkg.sv =====
// types and constants shared by the sorted-insert priority queue
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int DATA_W           = 32;
    localparam int COUNT_W          = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic                     removed_valid;
        logic                     overflow;
        logic [COUNT_W-1:0]       entry_count;
    } rsp_item_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                     occupied;
        logic                     above;
        logic signed [DATA_W-1:0] entry;
    } cell_link_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                     do_insert;
        logic                     do_remove;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// one cell of the sorted chain: holds one entry and its occupied bit
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  cell_link_t lower,
    input  cell_link_t upper,
    output cell_link_t link
);

    logic                     occupied_reg;
    logic                     occupied_next;
    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     above;

    // an empty cell counts as above any value
    assign above = !occupied_reg || (entry_reg > cmd.value);

    assign link.occupied = occupied_reg;
    assign link.above    = above;
    assign link.entry    = entry_reg;

    always_comb
    begin
        entry_next    = entry_reg;
        occupied_next = occupied_reg;
        if (cmd.do_insert)
        begin
            if (above)
            begin
                entry_next = lower.above ? lower.entry : cmd.value;
            end
            occupied_next = occupied_reg | lower.occupied;
        end
        else if (cmd.do_remove)
        begin
            entry_next    = upper.entry;
            occupied_next = upper.occupied;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
        end
        else
        begin
            occupied_reg <= occupied_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/core/sorted_insert_priority_queue_unit.sv =====
// Bounded priority queue built as a chain of CAPACITY cells. Cell 0 holds
// the smallest stored value, so a remove takes it from cell 0 while every
// cell takes its upper neighbor's entry; an insert lets each cell compare
// its entry with the new value at once and shift up or take the value.
// One item is accepted per cycle unless cmd_stall is high, and its result
// is registered in the cycle after; the cell chain needs only a single
// compare-and-shift step. The command side stalls only while a result
// sits in the output register and the receiver stalls it. entry_count
// reports the low five bits of the occupancy.
// depends on spq_pkg and spq_cell
`timescale 1ns / 1ps

module sorted_insert_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    cell_link_t      links [CAPACITY];
    cell_cmd_t       cell_cmd;
    logic            accept;
    logic            full;
    logic            empty;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW+4:0]   count_wide;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    rsp_item_t       rsp_reg;
    rsp_item_t       rsp_next;

    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign full      = links[CAPACITY-1].occupied;
    assign empty     = !links[0].occupied;

    assign cell_cmd.do_insert = accept && (cmd.operation == OP_INSERT) && !full;
    assign cell_cmd.do_remove = accept && (cmd.operation == OP_REMOVE) && !empty;
    assign cell_cmd.value     = cmd.value;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_link_t lower;
            cell_link_t upper;
            if (i == 0)
            begin : g_low_end
                assign lower = '{occupied: 1'b1, above: 1'b0, entry: '0};
            end
            else
            begin : g_low_mid
                assign lower = links[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_high_end
                assign upper = '{occupied: 1'b0, above: 1'b1, entry: '0};
            end
            else
            begin : g_high_mid
                assign upper = links[i+1];
            end
            spq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cell_cmd),
                .lower (lower),
                .upper (upper),
                .link  (links[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cell_cmd.do_insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cell_cmd.do_remove)
        begin
            count_next = count_reg - CW'(1);
        end
        count_wide = {5'b0, count_next};

        rsp_next               = rsp_reg;
        rsp_valid_next         = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.removed_value = cell_cmd.do_remove ? links[0].entry : '0;
            rsp_next.removed_valid = cell_cmd.do_remove;
            rsp_next.overflow      = (cmd.operation == OP_INSERT) && full;
            rsp_next.entry_count   = count_wide[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/spq_checker.sv =====
// port-level checks for the sorted-insert priority queue, bound to the top level
// depends on spq_pkg and sorted_insert_priority_queue_unit
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_stall,
    input cmd_item_t cmd,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> rsp_valid)
        else $error("accepted item produced no result");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (rsp_valid && rsp_stall))
        else $error("command stalled without a held result");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.removed_valid && rsp.overflow))
        else $error("removed and overflow both set");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.removed_valid) |-> (rsp.removed_value == '0))
        else $error("removed value nonzero without a removal");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

endmodule

bind sorted_insert_priority_queue_unit spq_checker u_spq_checker (.*);
